FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("assertion failed in %m");

// Expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk_i, rst_ni, expr) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
		else $error("forbidden condition in %m");

`else

`define ASSERT_AT(lbl, clk_i, rst_ni, prop)
`define ASSERT_NEVER(lbl, clk_i, rst_ni, expr)

`endif

`endif

FILE: rtl/dnd_pkg.sv
// ----------------------------------------------------------------------------
// Dense node delta decoder package
// Codes, result bundle and fixed constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnd_pkg;

	// Pipeline depth: request stage plus eight coordinate scaling stages
	localparam int NSTG = 9;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		CMD_GROUP_START = 2'd0,
		CMD_NODE        = 2'd1,
		CMD_TAG         = 2'd2,
		CMD_GROUP_END   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NODE  = 2'd0,
		KIND_TAG   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_INDEX    = 2'd1,
		ERR_MID_PAIR = 2'd2
	} err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRANULARITY  = 2'd0,
		REG_LAT_OFFSET   = 2'd1,
		REG_LON_OFFSET   = 2'd2,
		REG_STRING_COUNT = 2'd3
	} cfg_reg_t;

	// Non-coordinate fields of one result
	typedef struct packed {
		kind_t       kind;
		logic [63:0] id;
		logic [31:0] key;
		logic [31:0] value;
		err_t        err;
	} res_t;

	localparam logic [30:0] GRAN_RESET = 31'd100;

	// Rounding: floor((m + 50) / 100) on the magnitude
	localparam logic [37:0] RND_HALF = 38'd50;
	// Smallest magnitude whose rounded quotient reaches 2^31
	localparam logic [37:0] SAT_MAG = 38'd214748364750;
	// ceil(2^45 / 100); exact floor division for inputs below 2^38
	localparam logic [38:0] RECIP = 39'd351843720889;
	localparam int RECIP_SHIFT = 45;

	localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] COORD_MIN = 32'h8000_0000;

endpackage

FILE: rtl/dnd_front.sv
// ----------------------------------------------------------------------------
// Decoder front stage
// Running sums, tag pairing and error tracking; registers one result request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dnd_front import dnd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        ld_s1,
	input  logic [1:0]  command,
	input  logic [63:0] id_delta,
	input  logic [63:0] lat_delta,
	input  logic [63:0] lon_delta,
	input  logic [31:0] tag_word,
	input  logic [31:0] str_cnt,
	output logic        vld_s1,
	output res_t        res_s1,
	output logic [63:0] lat_s1,
	output logic [63:0] lon_s1
);

	logic [63:0] id_sum_q, lat_sum_q, lon_sum_q;
	logic [31:0] held_key_q;
	logic        pending_q, failed_q;

	logic [63:0] id_nx, lat_nx, lon_nx;
	logic [31:0] held_nx;
	logic        pending_nx, failed_nx;
	logic        emit;
	res_t        res;
	logic        bad_idx;

	assign bad_idx = (held_key_q >= str_cnt) || (tag_word >= str_cnt);

	// Decode one request against the running state
	always_comb begin
		id_nx      = id_sum_q;
		lat_nx     = lat_sum_q;
		lon_nx     = lon_sum_q;
		held_nx    = held_key_q;
		pending_nx = pending_q;
		failed_nx  = failed_q;
		emit       = 1'b0;
		res.kind   = KIND_NODE;
		res.id     = id_sum_q;
		res.key    = 32'd0;
		res.value  = 32'd0;
		res.err    = ERR_NONE;
		if (accept) begin
			case (cmd_t'(command))
				CMD_GROUP_START: begin
					id_nx      = 64'd0;
					lat_nx     = 64'd0;
					lon_nx     = 64'd0;
					held_nx    = 32'd0;
					pending_nx = 1'b0;
					failed_nx  = 1'b0;
				end
				CMD_NODE: begin
					if (!failed_q) begin
						id_nx    = id_sum_q + id_delta;
						lat_nx   = lat_sum_q + lat_delta;
						lon_nx   = lon_sum_q + lon_delta;
						emit     = 1'b1;
						res.kind = KIND_NODE;
						res.id   = id_nx;
					end
				end
				CMD_TAG: begin
					if (!failed_q) begin
						if (!pending_q) begin
							// zero in key position ends the node's tags
							if (tag_word != 32'd0) begin
								held_nx    = tag_word;
								pending_nx = 1'b1;
							end
						end else begin
							pending_nx = 1'b0;
							emit       = 1'b1;
							if (bad_idx) begin
								failed_nx = 1'b1;
								res.kind  = KIND_ERROR;
								res.id    = 64'd0;
								res.err   = ERR_INDEX;
							end else begin
								res.kind  = KIND_TAG;
								res.key   = held_key_q;
								res.value = tag_word;
							end
						end
					end
				end
				CMD_GROUP_END: begin
					if (!failed_q && pending_q) begin
						pending_nx = 1'b0;
						failed_nx  = 1'b1;
						emit       = 1'b1;
						res.kind   = KIND_ERROR;
						res.id     = 64'd0;
						res.err    = ERR_MID_PAIR;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_sum_q   <= 64'd0;
			lat_sum_q  <= 64'd0;
			lon_sum_q  <= 64'd0;
			held_key_q <= 32'd0;
			pending_q  <= 1'b0;
			failed_q   <= 1'b0;
		end else begin
			id_sum_q   <= id_nx;
			lat_sum_q  <= lat_nx;
			lon_sum_q  <= lon_nx;
			held_key_q <= held_nx;
			pending_q  <= pending_nx;
			failed_q   <= failed_nx;
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= emit;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			res_s1 <= res;
			lat_s1 <= lat_nx;
			lon_s1 <= lon_nx;
		end
	end

	`ASSERT_NEVER(a_pend_and_fail, clk, arst_n, pending_q && failed_q)
	`ASSERT_AT(a_pend_key, clk, arst_n, pending_q |-> (held_key_q != 32'd0))
	`ASSERT_AT(a_node_emits, clk, arst_n, accept && (command == CMD_NODE) && !failed_q |=> vld_s1)

endmodule

FILE: rtl/dnd_scale.sv
// ----------------------------------------------------------------------------
// Coordinate scaler
// (offset + granularity * sum) / 100, rounded half away from zero and
// saturated to signed 32 bits, over pipeline stages 2 to 9.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnd_scale import dnd_pkg::*; (
	input  logic            clk,
	input  logic [NSTG-1:0] ld,
	input  logic [63:0]     sum_s1,
	input  logic [30:0]     gran,
	input  logic [63:0]     offset,
	input  logic            node_s8,
	output logic [31:0]     coord_s9
);

	logic [62:0]        p_lo_s2;
	logic signed [63:0] p_hi_s2;
	logic [95:0]        prod_s3;
	logic [95:0]        v_s4;
	logic [95:0]        mag_s5;
	logic               neg_s5, neg_s6, neg_s7, neg_s8;
	logic               sat_s6, sat_s7, sat_s8;
	logic [37:0]        x_s6;
	logic [57:0]        pa_s7, pb_s7;
	logic [30:0]        q_s8;

	logic [76:0] full;
	logic [31:0] coord;

	assign full = {pa_s7, 19'd0} + {19'd0, pb_s7};

	// Saturate, apply sign, drop coordinates of non-node results
	always_comb begin
		if (!node_s8) begin
			coord = 32'd0;
		end else if (sat_s8) begin
			coord = neg_s8 ? COORD_MIN : COORD_MAX;
		end else if (neg_s8) begin
			coord = ~{1'b0, q_s8} + 32'd1;
		end else begin
			coord = {1'b0, q_s8};
		end
	end

	always_ff @(posedge clk) begin
		// split 64 x 31 product into two half-width partial products
		if (ld[1]) begin
			p_lo_s2 <= sum_s1[31:0] * gran;
			p_hi_s2 <= $signed(sum_s1[63:32]) * $signed({1'b0, gran});
		end
		// recombine partial products
		if (ld[2]) begin
			prod_s3 <= {p_hi_s2, 32'd0} + {33'd0, p_lo_s2};
		end
		// add offset
		if (ld[3]) begin
			v_s4 <= prod_s3 + {{32{offset[63]}}, offset};
		end
		// take magnitude
		if (ld[4]) begin
			neg_s5 <= v_s4[95];
			mag_s5 <= v_s4[95] ? (~v_s4 + 96'd1) : v_s4;
		end
		// saturation check and rounding bias
		if (ld[5]) begin
			neg_s6 <= neg_s5;
			sat_s6 <= (|mag_s5[95:38]) || (mag_s5[37:0] >= SAT_MAG);
			x_s6   <= mag_s5[37:0] + RND_HALF;
		end
		// divide by 100: reciprocal partial products
		if (ld[6]) begin
			neg_s7 <= neg_s6;
			sat_s7 <= sat_s6;
			pa_s7  <= x_s6[37:19] * RECIP;
			pb_s7  <= x_s6[18:0] * RECIP;
		end
		// quotient
		if (ld[7]) begin
			neg_s8 <= neg_s7;
			sat_s8 <= sat_s7;
			q_s8   <= full[RECIP_SHIFT+30:RECIP_SHIFT];
		end
		if (ld[8]) begin
			coord_s9 <= coord;
		end
	end

endmodule

FILE: rtl/dnd_side.sv
// ----------------------------------------------------------------------------
// Result pipeline control
// Stage valids, load enables with bubble collapse, and the result fields
// that ride alongside the coordinate scalers up to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dnd_side import dnd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_s1,
	input  res_t            res_s1,
	input  logic            out_stall,
	output logic [NSTG-1:0] ld,
	output logic            node_s8,
	output logic            out_valid,
	output logic [1:0]      kind,
	output logic [63:0]     node_id,
	output logic [31:0]     tag_key,
	output logic [31:0]     tag_value,
	output logic [1:0]      error_code
);

	logic [NSTG:2] vld_q;
	res_t          res_q [2:NSTG];

	logic [NSTG:1] vld_all;
	res_t          res_all [1:NSTG];

	assign vld_all = {vld_q, vld_s1};

	// Load a stage when it is empty or its successor moves on
	always_comb begin
		ld[NSTG-1] = !vld_all[NSTG] || !out_stall;
		for (int n = NSTG - 1; n >= 1; n--) begin
			ld[n-1] = !vld_all[n] || ld[n];
		end
	end

	always_comb begin
		res_all[1] = res_s1;
		for (int n = 2; n <= NSTG; n++) begin
			res_all[n] = res_q[n];
		end
	end

	// Advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int n = 2; n <= NSTG; n++) begin
				if (ld[n-1]) begin
					vld_q[n] <= vld_all[n-1];
				end
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		for (int n = 2; n <= NSTG; n++) begin
			if (ld[n-1]) begin
				res_q[n] <= res_all[n-1];
			end
		end
	end

	assign node_s8    = (res_q[NSTG-1].kind == KIND_NODE);
	assign out_valid  = vld_q[NSTG];
	assign kind       = res_q[NSTG].kind;
	assign node_id    = res_q[NSTG].id;
	assign tag_key    = res_q[NSTG].key;
	assign tag_value  = res_q[NSTG].value;
	assign error_code = res_q[NSTG].err;

	`ASSERT_NEVER(a_stall_only_full, clk, arst_n, !ld[0] && !(vld_s1 && (&vld_q) && out_stall))
	`ASSERT_AT(a_err_kind, clk, arst_n, out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))

endmodule

FILE: rtl/dense_node_delta_decoder.sv
// ----------------------------------------------------------------------------
// Dense node delta decoder
// Takes one request per cycle while in_stall is low, with no gaps required. A
// request that yields a result (node, tag pair or error) passes one decode
// stage and then the eight-stage coordinate scaler (two partial-product
// multiplies, a 96-bit recombine, the offset add, magnitude, rounding, a
// reciprocal divide by 100 and saturation) into the output register. Requests
// that yield no result update state and leave no slot in the pipeline. A
// stall on the output fills empty slots first and only then stalls the input,
// so up to 9 results can be in flight. The string count applies to requests
// accepted after its write; granularity and offsets are read in the scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dense_node_delta_decoder import dnd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic signed [63:0]   id_delta,
	input  logic signed [63:0]   lat_delta,
	input  logic signed [63:0]   lon_delta,
	input  logic [31:0]          tag_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic signed [63:0]   node_id,
	output logic signed [31:0]   lat_coord,
	output logic signed [31:0]   lon_coord,
	output logic [31:0]          tag_key,
	output logic [31:0]          tag_value,
	output logic [1:0]           error_code
);

	logic [30:0] gran_q;
	logic [63:0] lat_off_q, lon_off_q;
	logic [31:0] str_cnt_q;

	logic [NSTG-1:0] ld;
	logic            accept;
	logic            vld_s1;
	res_t            res_s1;
	logic [63:0]     lat_s1, lon_s1;
	logic            node_s8;

	assign in_stall = !ld[0];
	assign accept   = in_valid && ld[0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gran_q    <= GRAN_RESET;
			lat_off_q <= 64'd0;
			lon_off_q <= 64'd0;
			str_cnt_q <= 32'd0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRANULARITY:  gran_q    <= cfg_data[30:0];
				REG_LAT_OFFSET:   lat_off_q <= cfg_data;
				REG_LON_OFFSET:   lon_off_q <= cfg_data;
				REG_STRING_COUNT: str_cnt_q <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	dnd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.ld_s1     (ld[0]),
		.command   (command),
		.id_delta  (id_delta),
		.lat_delta (lat_delta),
		.lon_delta (lon_delta),
		.tag_word  (tag_word),
		.str_cnt   (str_cnt_q),
		.vld_s1    (vld_s1),
		.res_s1    (res_s1),
		.lat_s1    (lat_s1),
		.lon_s1    (lon_s1)
	);

	dnd_scale u_lat (
		.clk      (clk),
		.ld       (ld),
		.sum_s1   (lat_s1),
		.gran     (gran_q),
		.offset   (lat_off_q),
		.node_s8  (node_s8),
		.coord_s9 (lat_coord)
	);

	dnd_scale u_lon (
		.clk      (clk),
		.ld       (ld),
		.sum_s1   (lon_s1),
		.gran     (gran_q),
		.offset   (lon_off_q),
		.node_s8  (node_s8),
		.coord_s9 (lon_coord)
	);

	dnd_side u_side (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_s1     (vld_s1),
		.res_s1     (res_s1),
		.out_stall  (out_stall),
		.ld         (ld),
		.node_s8    (node_s8),
		.out_valid  (out_valid),
		.kind       (kind),
		.node_id    (node_id),
		.tag_key    (tag_key),
		.tag_value  (tag_value),
		.error_code (error_code)
	);

endmodule

FILE: tb/tb_dense_node_delta_decoder.sv
// ----------------------------------------------------------------------------
// Dense node delta decoder testbench
// Drives group, node, tag and group-end requests through the decoder with
// random sender bursts and receiver stalls, predicts every node, tag pair and
// error result in the bench, and checks each result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dense_node_delta_decoder;
	import dnd_pkg::*;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam int RANDOM_ITEMS = 600;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_LIMIT = 4000;

	// One request as the sender offers it
	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] id_d;
		logic [63:0] lat_d;
		logic [63:0] lon_d;
		logic [31:0] word;
	} dn_item_t;

	// One decoded result as the block should deliver it
	typedef struct packed {
		kind_t       kind;
		logic [63:0] id;
		logic [31:0] lat;
		logic [31:0] lon;
		logic [31:0] key;
		logic [31:0] val;
		err_t        err;
	} decoded_t;

	typedef struct {
		bit          is_cfg;
		cfg_reg_t    sel;
		logic [63:0] val;
		dn_item_t    it;
		bit          typed;
		decoded_t    res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           command = '0;
	logic [63:0]          id_delta = '0;
	logic [63:0]          lat_delta = '0;
	logic [63:0]          lon_delta = '0;
	logic [31:0]          tag_word = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           kind;
	logic signed [63:0]   node_id;
	logic signed [31:0]   lat_coord;
	logic signed [31:0]   lon_coord;
	logic [31:0]          tag_key;
	logic [31:0]          tag_value;
	logic [1:0]           error_code;

	dense_node_delta_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.id_delta   (id_delta),
		.lat_delta  (lat_delta),
		.lon_delta  (lon_delta),
		.tag_word   (tag_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.node_id    (node_id),
		.lat_coord  (lat_coord),
		.lon_coord  (lon_coord),
		.tag_key    (tag_key),
		.tag_value  (tag_value),
		.error_code (error_code)
	);

	// Bench copy of the registers and decoder state
	logic [30:0] gran_r = 31'd100;
	logic [63:0] lat_off_r = '0;
	logic [63:0] lon_off_r = '0;
	logic [31:0] str_cnt_r = '0;
	logic [63:0] id_acc = '0;
	logic [63:0] lat_acc = '0;
	logic [63:0] lon_acc = '0;
	logic [31:0] pend_key = '0;
	bit          key_waiting = 1'b0;
	bit          group_failed = 1'b0;

	decoded_t decoded_fifo [$];
	int unsigned faults = 0;
	int unsigned served = 0;
	int unsigned config_writes = 0;
	int unsigned n_node = 0, n_tag = 0, n_err = 0;
	int unsigned burst_left = 0;
	bit          hold_off_req = 1'b0;

	// Directed requests; typed rows carry a result read straight off the spec
	dir_row_t dir_tab [0:28] = '{
		'{1'b0, REG_GRANULARITY, '0, '{CMD_NODE, 64'd5, 64'd7, -64'sd3, 32'd0}, 1'b1,
			'{KIND_NODE, 64'd5, 32'd7, -32'sd3, 32'd0, 32'd0, ERR_NONE}},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_GROUP_START, '0, '0, '0, '0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0,
			'{CMD_NODE, S64_MAX, 64'd2147483647, -64'sd2147483648, 32'd0}, 1'b1,
			'{KIND_NODE, S64_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, ERR_NONE}},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_NODE, 64'd1, 64'd1, -64'sd1, 32'd0}, 1'b1,
			'{KIND_NODE, S64_MIN, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, ERR_NONE}},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_GROUP_START, '0, '0, '0, '0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_NODE, S64_MIN, S64_MIN, S64_MAX, 32'd0}, 1'b1,
			'{KIND_NODE, S64_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, ERR_NONE}},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd3}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd0}, 1'b1,
			'{KIND_ERROR, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, ERR_INDEX}},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_NODE, 64'd1, 64'd1, 64'd1, 32'd0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_GROUP_START, '0, '0, '0, '0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'hFFFF_FFFF}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_GROUP_END, '0, '0, '0, '0}, 1'b1,
			'{KIND_ERROR, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, ERR_MID_PAIR}},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_GROUP_START, '0, '0, '0, '0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_GROUP_END, '0, '0, '0, '0}, 1'b0, '0},
		'{1'b1, REG_STRING_COUNT, 64'd10, '0, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_NODE, 64'd1, 64'd2, 64'd3, 32'd0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd4}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_NODE, 64'd1, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd9}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd10}, 1'b1,
			'{KIND_ERROR, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, ERR_INDEX}},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_GROUP_START, '0, '0, '0, '0}, 1'b0, '0},
		'{1'b1, REG_GRANULARITY, 64'd0, '0, 1'b0, '0},
		'{1'b1, REG_LAT_OFFSET, 64'd149, '0, 1'b0, '0},
		'{1'b1, REG_LON_OFFSET, -64'sd150, '0, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_NODE, 64'd7, 64'd5, 64'd5, 32'd0}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd9}, 1'b0, '0},
		'{1'b0, REG_GRANULARITY, '0, '{CMD_TAG, '0, '0, '0, 32'd9}, 1'b0, '0}
	};

	// Scale a coordinate sum: (offset + granularity * sum) / 100, round, saturate
	function automatic logic [31:0] to_coord(input logic [63:0] acc, input logic [63:0] off);
		logic signed [127:0] a, g, o, t;
		logic [127:0] mag, q;
		a = $signed(acc);
		g = {97'd0, gran_r};
		o = $signed(off);
		t = a * g + o;
		mag = t[127] ? -t : t;
		q = (mag + 128'd50) / 128'd100;
		if (t[127])
			return (q >= 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
		return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	// Advance the decoder state by one request; return 1 when it yields a result
	function automatic bit decode_item(input dn_item_t it, output decoded_t r);
		r = '0;
		if (it.cmd == CMD_GROUP_START) begin
			id_acc = '0;
			lat_acc = '0;
			lon_acc = '0;
			pend_key = '0;
			key_waiting = 1'b0;
			group_failed = 1'b0;
			return 1'b0;
		end
		if (group_failed)
			return 1'b0;
		if (it.cmd == CMD_NODE) begin
			id_acc = id_acc + it.id_d;
			lat_acc = lat_acc + it.lat_d;
			lon_acc = lon_acc + it.lon_d;
			r.kind = KIND_NODE;
			r.id = id_acc;
			r.lat = to_coord(lat_acc, lat_off_r);
			r.lon = to_coord(lon_acc, lon_off_r);
			return 1'b1;
		end
		if (it.cmd == CMD_TAG) begin
			if (!key_waiting) begin
				// zero in key position ends the node's tags
				if (it.word != '0) begin
					pend_key = it.word;
					key_waiting = 1'b1;
				end
				return 1'b0;
			end
			key_waiting = 1'b0;
			if (pend_key >= str_cnt_r || it.word >= str_cnt_r) begin
				group_failed = 1'b1;
				r.kind = KIND_ERROR;
				r.err = ERR_INDEX;
				return 1'b1;
			end
			r.kind = KIND_TAG;
			r.id = id_acc;
			r.key = pend_key;
			r.val = it.word;
			return 1'b1;
		end
		// group end: only a dangling key is an error
		if (key_waiting) begin
			key_waiting = 1'b0;
			group_failed = 1'b1;
			r.kind = KIND_ERROR;
			r.err = ERR_MID_PAIR;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			faults++;
		end
	endfunction

	function automatic logic [63:0] rand_delta();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return {$urandom, r};
			1: return ($urandom_range(0, 1) != 0) ? S64_MAX : S64_MIN;
			2, 3: return {{32{r[31]}}, r};
			default: return 64'($urandom_range(0, 10000)) - 64'd5000;
		endcase
	endfunction

	function automatic logic [63:0] rand_offset();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: return {$urandom, r};
			1: return '0;
			default: return {{32{r[31]}}, r};
		endcase
	endfunction

	// Request of one command with random filler in the fields it does not use
	function automatic dn_item_t mk(input cmd_t c);
		dn_item_t it;
		it.cmd = c;
		it.id_d = {$urandom, $urandom};
		it.lat_d = {$urandom, $urandom};
		it.lon_d = {$urandom, $urandom};
		it.word = $urandom;
		return it;
	endfunction

	function automatic dn_item_t tag_item(input logic [31:0] w);
		dn_item_t it;
		it = mk(CMD_TAG);
		it.word = w;
		return it;
	endfunction

	// Mostly in-range key, sometimes the bound or a wild index
	function automatic logic [31:0] index_word(input bit key_pos);
		int unsigned sel;
		sel = $urandom_range(0, 11);
		if (sel == 0 || str_cnt_r == '0 || (key_pos && str_cnt_r == 32'd1))
			return $urandom;
		if (sel == 1)
			return str_cnt_r;
		return key_pos ? $urandom_range(1, str_cnt_r - 1) : $urandom_range(0, str_cnt_r - 1);
	endfunction

	// Offer one request in the sender's burst pattern; predict it when accepted
	task automatic offer(input dn_item_t it, input bit typed = 1'b0,
			input decoded_t fixed = '0);
		decoded_t r;
		bit has;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 30);
		end
		command <= it.cmd;
		id_delta <= it.id_d;
		lat_delta <= it.lat_d;
		lon_delta <= it.lon_d;
		tag_word <= it.word;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		served++;
		has = decode_item(it, r);
		if (typed)
			decoded_fifo.insert(decoded_fifo.size(), fixed);
		else if (has)
			decoded_fifo.insert(decoded_fifo.size(), r);
		burst_left--;
		@(negedge clk);
	endtask

	// Drop valid and wait until every result is out and the pipeline is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (decoded_fifo.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [63:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		case (sel)
			REG_GRANULARITY: gran_r = v[30:0];
			REG_LAT_OFFSET: lat_off_r = v;
			REG_LON_OFFSET: lon_off_r = v;
			REG_STRING_COUNT: str_cnt_r = v[31:0];
			default: ;
		endcase
		config_writes++;
	endtask

	// One well-formed group with random content and occasional breakage
	task automatic run_group();
		dn_item_t it;
		offer(mk(CMD_GROUP_START));
		repeat ($urandom_range(1, 6)) begin
			it = mk(CMD_NODE);
			it.id_d = ($urandom_range(0, 7) == 0) ? rand_delta() : 64'($urandom_range(1, 1000));
			it.lat_d = rand_delta();
			it.lon_d = rand_delta();
			offer(it);
			repeat ($urandom_range(0, 3)) begin
				offer(tag_item(index_word(1'b1)));
				offer(tag_item(index_word(1'b0)));
			end
			if ($urandom_range(0, 9) != 0)
				offer(tag_item('0));
			if ($urandom_range(0, 19) == 0)
				offer(mk(cmd_t'($urandom_range(0, 3))));
		end
		// leave a key dangling now and then
		if ($urandom_range(0, 9) == 0)
			offer(tag_item(index_word(1'b1)));
		if ($urandom_range(0, 9) != 0)
			offer(mk(CMD_GROUP_END));
	endtask

	initial begin : clock_gen
		forever #1 clk = ~clk;
	end

	// Receiver: own stall pattern, plus a long hold-off on request
	initial begin : receiver
		int unsigned seg_left, mode, hold_left;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
				if (hold_left == 0)
					hold_off_req = 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= (seg_left % 4 != 0);
				endcase
			end
		end
	end

	// Compare each delivered result with the oldest prediction
	always @(posedge clk) begin : result_check
		decoded_t e;
		if (out_valid && !out_stall) begin
			if (decoded_fifo.size() == 0) begin
				$error("unexpected result: kind %0d id %0h", kind, node_id);
				faults++;
			end else begin
				e = decoded_fifo.pop_front();
				check_field("kind", 64'(e.kind), 64'(kind));
				check_field("node_id", e.id, node_id);
				check_field("lat_coord", 64'(e.lat), 64'($unsigned(lat_coord)));
				check_field("lon_coord", 64'(e.lon), 64'($unsigned(lon_coord)));
				check_field("tag_key", 64'(e.key), 64'(tag_key));
				check_field("tag_value", 64'(e.val), 64'(tag_value));
				check_field("error_code", 64'(e.err), 64'(error_code));
				case (e.kind)
					KIND_NODE: n_node++;
					KIND_TAG: n_tag++;
					default: n_err++;
				endcase
			end
		end
	end

	// Abort if neither side moves a request for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no progress for %0d cycles", IDLE_LIMIT);
		$display("dense_node_delta_decoder verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase, goal, phase_goal;
		logic [30:0] g;
		logic [63:0] lo, ln;
		logic [31:0] sc;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle();
				write_reg(dir_tab[i].sel, dir_tab[i].val);
			end else begin
				offer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
			end
		end

		// random phases, each under its own register setting
		goal = served + RANDOM_ITEMS;
		phase = 0;
		while (served < goal) begin
			settle();
			case (phase)
				0: begin
					g = 31'h7FFF_FFFF;
					lo = S64_MIN;
					ln = S64_MAX;
					sc = 32'hFFFF_FFFF;
				end
				1: begin
					g = 31'd1;
					lo = S64_MAX;
					ln = S64_MIN;
					sc = $urandom_range(2, 64);
				end
				default: begin
					g = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1000));
					lo = rand_offset();
					ln = rand_offset();
					sc = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 200);
				end
			endcase
			write_reg(REG_GRANULARITY, {$urandom, 1'($urandom), g});
			write_reg(REG_LAT_OFFSET, lo);
			write_reg(REG_LON_OFFSET, ln);
			write_reg(REG_STRING_COUNT, {$urandom, sc});
			// back up the output so the pipeline fills and stalls its input
			if (phase == 2)
				hold_off_req = 1'b1;
			phase_goal = served + 100;
			while (served < phase_goal)
				run_group();
			phase++;
		end

		settle();
		repeat (20) @(negedge clk);
		if (decoded_fifo.size() != 0) begin
			$error("%0d expected results never arrived", decoded_fifo.size());
			faults++;
		end
		$display("run: %0d requests, %0d register writes over %0d random settings",
			served, config_writes, phase);
		$display("results: %0d nodes, %0d tag pairs, %0d errors, %0d mismatches",
			n_node, n_tag, n_err, faults);
		if (faults == 0)
			$display("dense_node_delta_decoder verification clean");
		else
			$display("dense_node_delta_decoder verification failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dnd_pkg.sv
rtl/dnd_front.sv
rtl/dnd_scale.sv
rtl/dnd_side.sv
rtl/dense_node_delta_decoder.sv
tb/tb_dense_node_delta_decoder.sv
